// File: rtl/fss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fss_pkg
// Shared types and constants of the fuzzy subsequence scorer: query layout,
// score width, award values and the ascii case fold.
// ----------------------------------------------------------------------------
package fss_pkg;

    localparam int QUERY_CHARS = 16;
    localparam int CHAR_W      = 8;
    localparam int QLEN_W      = 5;
    localparam int SCORE_W     = 10;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 2;

    // largest query length that is honored; longer settings clamp here
    localparam logic [QLEN_W-1:0] MAX_QUERY = QLEN_W'(16);

    localparam logic [7:0]         MATCH_AWARD = 8'd10;
    localparam logic [7:0]         FIRST_AWARD = 8'd20;
    localparam logic [SCORE_W-1:0] RUN_AWARD   = SCORE_W'(5);
    localparam logic [SCORE_W-1:0] EMPTY_SCORE = SCORE_W'(100);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_QUERY_LOW  = 2'd0,
        REG_QUERY_HIGH = 2'd1,
        REG_QUERY_LEN  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [QUERY_CHARS-1:0][CHAR_W-1:0] chars;
        logic [QLEN_W-1:0]                  len;   // already clamped
    } query_t;

    function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5a) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/fuzzy_subsequence_scorer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fuzzy_subsequence_scorer_unit
// Case-insensitive fuzzy subsequence scoring of a streamed text against a
// configured query of up to 16 characters.
//
// Usage: write the query through cfg_wr_en / cfg_addr / cfg_wr_data while
// the block is idle (index 0 chars 0-7, 1 chars 8-15, 2 length). Text bytes
// arrive on the s_ channel, one item per byte; s_last_char marks the final
// byte and s_empty_text stands for a whole empty text. One score item leaves
// on the m_ channel for each final or empty-text item, none for other bytes.
// A score is valid on m_ once its item has passed the input register and the
// result register. Throughput: one item per cycle while the receiver takes
// each score, set by the state update between the two registers.
// Reset clears the query registers, the per-text state and both valid
// flags. When the receiver stalls, the held score keeps its value, bytes
// that give no score still flow through, and s_ready drops once a scoring
// item waits in the input register behind the held score.
// ----------------------------------------------------------------------------
module fuzzy_subsequence_scorer_unit #(
    parameter int MAX_TEXT = 1023
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               cfg_wr_en,
    input  wire logic [fss_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [fss_pkg::CFG_DATA_W-1:0]     cfg_wr_data,

    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [fss_pkg::CHAR_W-1:0]         s_text_char,
    input  wire logic                               s_last_char,
    input  wire logic                               s_empty_text,

    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [fss_pkg::SCORE_W-1:0]      m_match_score
);

    fss_pkg::query_t query;

    logic                          in_valid_reg;
    logic [fss_pkg::CHAR_W-1:0]    in_char_reg;
    logic                          in_last_reg;
    logic                          in_empty_reg;
    logic                          out_valid_reg;
    logic [fss_pkg::SCORE_W-1:0]   out_score_reg;

    logic                          has_result;
    logic                          advance;
    logic [fss_pkg::SCORE_W-1:0]   core_score;

    fss_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .query       (query)
    );

    fss_core #(
        .MAX_TEXT (MAX_TEXT)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .query      (query),
        .step       (advance),
        .text_char  (in_char_reg),
        .last_char  (in_last_reg),
        .empty_text (in_empty_reg),
        .score      (core_score)
    );

    // bytes without a score never wait on the output side
    assign has_result = in_last_reg | in_empty_reg;
    assign advance    = in_valid_reg & (~has_result | ~out_valid_reg | m_ready);
    assign s_ready    = ~in_valid_reg | advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg  <= s_text_char;
            in_last_reg  <= s_last_char;
            in_empty_reg <= s_empty_text;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && has_result) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && has_result) begin
            out_score_reg <= core_score;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_match_score = out_score_reg;

endmodule
`default_nettype wire

// File: rtl/fss_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fss_cfg
// Query configuration registers with the length clamp applied on read.
// ----------------------------------------------------------------------------
module fss_cfg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [fss_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [fss_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    output fss_pkg::query_t                     query
);

    logic [fss_pkg::CFG_DATA_W-1:0] chars_low_reg;
    logic [fss_pkg::CFG_DATA_W-1:0] chars_high_reg;
    logic [fss_pkg::QLEN_W-1:0]     len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chars_low_reg  <= '0;
            chars_high_reg <= '0;
            len_reg        <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                fss_pkg::REG_QUERY_LOW:  chars_low_reg  <= cfg_wr_data;
                fss_pkg::REG_QUERY_HIGH: chars_high_reg <= cfg_wr_data;
                fss_pkg::REG_QUERY_LEN:  len_reg <= cfg_wr_data[fss_pkg::QLEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        query.chars = {chars_high_reg, chars_low_reg};
        query.len   = (len_reg > fss_pkg::MAX_QUERY) ? fss_pkg::MAX_QUERY : len_reg;
    end

endmodule
`default_nettype wire

// File: rtl/fss_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fss_core
// Per-text match state: query position, runs, awards and text length kept
// as a ones digit and a tens count, plus the score of the finishing item.
// ----------------------------------------------------------------------------
module fss_core #(
    parameter int MAX_TEXT = 1023
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire fss_pkg::query_t                   query,
    input  wire logic                              step,
    input  wire logic [fss_pkg::CHAR_W-1:0]        text_char,
    input  wire logic                              last_char,
    input  wire logic                              empty_text,
    output logic      [fss_pkg::SCORE_W-1:0]       score
);

    localparam int LEN_W  = $clog2(MAX_TEXT + 1);
    localparam int TENS_W = (MAX_TEXT / 10 >= 1) ? $clog2(MAX_TEXT / 10 + 1) : 1;
    localparam int SW     = fss_pkg::SCORE_W;
    localparam int QW     = fss_pkg::QLEN_W;

    logic [fss_pkg::QLEN_W-1:0] qpos_reg, qpos_next;
    logic [fss_pkg::QLEN_W-1:0] run_reg, run_next;
    logic [fss_pkg::QLEN_W-1:0] longest_reg, longest_next;
    logic [7:0]                 points_reg, points_next;
    logic [LEN_W-1:0]           len_reg, len_next;
    logic [3:0]                 digit_reg, digit_next;
    logic [TENS_W-1:0]          tens_reg, tens_next;

    logic [fss_pkg::CHAR_W-1:0] qchar;
    logic                       hit;
    logic [SW+TENS_W-1:0]       tens_wide;
    logic [SW-1:0]              full_score;

    always_comb begin
        qchar = query.chars[qpos_reg[fss_pkg::QLEN_W-2:0]];
        hit   = (fss_pkg::fold(text_char) == fss_pkg::fold(qchar));

        qpos_next    = qpos_reg;
        run_next     = run_reg;
        longest_next = longest_reg;
        points_next  = points_reg;
        len_next     = len_reg;
        digit_next   = digit_reg;
        tens_next    = tens_reg;

        if (qpos_reg < query.len) begin
            if (hit) begin
                qpos_next = qpos_reg + QW'(1);
                run_next  = run_reg + QW'(1);
                if (run_next > longest_reg) begin
                    longest_next = run_next;
                end
                points_next = points_reg + fss_pkg::MATCH_AWARD;
                if (len_reg == '0) begin
                    points_next = points_next + fss_pkg::FIRST_AWARD;
                end
            end else begin
                run_next = '0;
            end
        end

        // length saturates; digit and tens track length / 10 without a divider
        if (len_reg < LEN_W'(MAX_TEXT)) begin
            len_next = len_reg + LEN_W'(1);
            if (digit_reg == 4'd9) begin
                digit_next = '0;
                tens_next  = tens_reg + TENS_W'(1);
            end else begin
                digit_next = digit_reg + 4'd1;
            end
        end

        // modulo 2^10 arithmetic gives the masked score directly
        tens_wide  = {{SW{1'b0}}, tens_next};
        full_score = SW'(points_next) + SW'(longest_next) * fss_pkg::RUN_AWARD
                   - tens_wide[SW-1:0];

        if (empty_text) begin
            score = (query.len == '0) ? fss_pkg::EMPTY_SCORE : '0;
        end else if (query.len == '0) begin
            score = fss_pkg::EMPTY_SCORE;
        end else if (qpos_next < query.len) begin
            score = '0;
        end else begin
            score = full_score;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qpos_reg    <= '0;
            run_reg     <= '0;
            longest_reg <= '0;
            points_reg  <= '0;
            len_reg     <= '0;
            digit_reg   <= '0;
            tens_reg    <= '0;
        end else if (step) begin
            if (empty_text || last_char) begin
                qpos_reg    <= '0;
                run_reg     <= '0;
                longest_reg <= '0;
                points_reg  <= '0;
                len_reg     <= '0;
                digit_reg   <= '0;
                tens_reg    <= '0;
            end else begin
                qpos_reg    <= qpos_next;
                run_reg     <= run_next;
                longest_reg <= longest_next;
                points_reg  <= points_next;
                len_reg     <= len_next;
                digit_reg   <= digit_next;
                tens_reg    <= tens_next;
            end
        end
    end

endmodule
`default_nettype wire
